// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define MMN_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MMN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mmn_pkg.sv =====
// shared constants, codes and types of the min-max normaliser
package mmn_pkg;

	localparam int SAMPLE_WIDTH  = 32;
	localparam int FRACTION_BITS = 16;
	localparam int EXT_W         = SAMPLE_WIDTH + 1;
	localparam int NUM_W         = SAMPLE_WIDTH + 9;
	localparam int PIX_W         = 8;
	localparam int STEP_W        = $clog2(PIX_W);
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] OP_CLEAR     = 2'd0;
	localparam logic [1:0] OP_MEASURE   = 2'd1;
	localparam logic [1:0] OP_NORMALIZE = 2'd2;

	localparam logic [1:0] KIND_ZERO = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_DIV  = 2'd2;

	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] RANGE_ONE =
		{{(SAMPLE_WIDTH-1){1'b0}}, 1'b1} << FRACTION_BITS;
	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

	typedef struct packed {
		logic [1:0]              kind;
		logic                    flat;
		logic [SAMPLE_WIDTH-1:0] dividend;
		logic [SAMPLE_WIDTH-1:0] divisor;
	} mmn_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mmn_qstat_t;

endpackage

// ===== rtl/mmn_front.sv =====
// front end: takes words, keeps frame statistics and classifies normalise jobs
module mmn_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [1:0]                       opcode,
	input  logic signed [31:0]               sample,
	input  mmn_pkg::mmn_qstat_t              qstat,
	output logic                             push,
	output mmn_pkg::mmn_job_t                push_job
);

	logic signed [mmn_pkg::SAMPLE_WIDTH-1:0] min_q, max_q, s_w;
	logic signed [mmn_pkg::EXT_W-1:0]        s_ext, min_ext, max_ext, diff_c, range_c;
	logic signed [mmn_pkg::EXT_W-1:0]        diff_s1, range_s1;
	logic                                    norm_valid_s1;
	logic                                    accept, range_pos, diff_le0, diff_ge;
	logic [mmn_pkg::SAMPLE_WIDTH-1:0]        r_eff;

	assign s_w     = sample[mmn_pkg::SAMPLE_WIDTH-1:0];
	assign s_ext   = {s_w[mmn_pkg::SAMPLE_WIDTH-1], s_w};
	assign min_ext = {min_q[mmn_pkg::SAMPLE_WIDTH-1], min_q};
	assign max_ext = {max_q[mmn_pkg::SAMPLE_WIDTH-1], max_q};
	assign diff_c  = s_ext - min_ext;
	assign range_c = max_ext - min_ext;

	assign item_stall = norm_valid_s1 && qstat.full;
	assign accept     = item_valid && !item_stall;
	assign push       = norm_valid_s1 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= mmn_pkg::SAMPLE_MAX;
			max_q <= mmn_pkg::SAMPLE_MIN;
		end else if (accept) begin
			case (opcode)
				mmn_pkg::OP_CLEAR: begin
					min_q <= mmn_pkg::SAMPLE_MAX;
					max_q <= mmn_pkg::SAMPLE_MIN;
				end
				mmn_pkg::OP_MEASURE: begin
					if (s_w < min_q) min_q <= s_w;
					if (s_w > max_q) max_q <= s_w;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_valid_s1 <= 1'b0;
		end else if (accept && opcode == mmn_pkg::OP_NORMALIZE) begin
			norm_valid_s1 <= 1'b1;
		end else if (push) begin
			norm_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == mmn_pkg::OP_NORMALIZE) begin
			diff_s1  <= diff_c;
			range_s1 <= range_c;
		end
	end

	// flat frame falls back to a range of one
	assign range_pos = !range_s1[mmn_pkg::EXT_W-1] && (range_s1 != '0);
	assign r_eff     = range_pos ? range_s1[mmn_pkg::SAMPLE_WIDTH-1:0] : mmn_pkg::RANGE_ONE;
	assign diff_le0  = diff_s1[mmn_pkg::EXT_W-1] || (diff_s1 == '0);
	assign diff_ge   = diff_s1 >= $signed({1'b0, r_eff});

	always_comb begin
		push_job.flat     = !range_pos;
		push_job.dividend = diff_s1[mmn_pkg::SAMPLE_WIDTH-1:0];
		push_job.divisor  = r_eff;
		if (diff_le0) push_job.kind = mmn_pkg::KIND_ZERO;
		else if (diff_ge) push_job.kind = mmn_pkg::KIND_FULL;
		else push_job.kind = mmn_pkg::KIND_DIV;
	end

endmodule

// ===== rtl/mmn_queue.sv =====
// short job queue between front end and divider
module mmn_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mmn_pkg::mmn_job_t   push_job,
	input  logic                pop,
	output mmn_pkg::mmn_job_t   pop_job,
	output mmn_pkg::mmn_qstat_t qstat
);

	mmn_pkg::mmn_job_t          entry_q [mmn_pkg::QUEUE_DEPTH];
	logic [mmn_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mmn_pkg::QPTR_W:0]   count_q;

	assign qstat.full  = count_q == (mmn_pkg::QPTR_W+1)'(mmn_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign pop_job     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

endmodule

// ===== rtl/mmn_back.sv =====
// back end: restoring divider and output register
module mmn_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mmn_pkg::mmn_job_t         job,
	input  mmn_pkg::mmn_qstat_t       qstat,
	output logic                      pop,
	output logic                      pix_valid,
	input  logic                      pix_stall,
	output logic [mmn_pkg::PIX_W-1:0] pixel,
	output logic                      flat_frame
);

	logic                             busy_q, flat_q, out_valid_q, out_flat_q;
	logic [mmn_pkg::STEP_W-1:0]       step_q;
	logic [mmn_pkg::NUM_W-1:0]        rem_q, dsh_q, num_c, dividend_w, divisor_w;
	logic [mmn_pkg::NUM_W:0]          trial;
	logic [mmn_pkg::PIX_W-2:0]        quot_q;
	logic [mmn_pkg::PIX_W-1:0]        out_pix_q;
	logic                             out_free, bit_ok, last, step_en, direct;

	assign out_free = !out_valid_q || !pix_stall;
	assign pop      = !busy_q && !qstat.empty && (job.kind == mmn_pkg::KIND_DIV || out_free);
	assign direct   = pop && job.kind != mmn_pkg::KIND_DIV;

	// 510 d + r, with 510 d as 512 d - 2 d
	assign dividend_w = mmn_pkg::NUM_W'(job.dividend);
	assign divisor_w  = mmn_pkg::NUM_W'(job.divisor);
	assign num_c      = (dividend_w << 9) - (dividend_w << 1) + divisor_w;

	assign trial   = {1'b0, rem_q} - {1'b0, dsh_q};
	assign bit_ok  = !trial[mmn_pkg::NUM_W];
	assign last    = busy_q && step_q == '0;
	assign step_en = busy_q && (!last || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (pop && job.kind == mmn_pkg::KIND_DIV) begin
			busy_q <= 1'b1;
			step_q <= mmn_pkg::STEP_W'(mmn_pkg::PIX_W - 1);
		end else if (step_en) begin
			if (last) busy_q <= 1'b0;
			step_q <= step_q - 1'b1;
		end
	end

	// divisor 2r aligned to the top quotient bit: 2r << 7 = r << 8
	always_ff @(posedge clk) begin
		if (pop && job.kind == mmn_pkg::KIND_DIV) begin
			rem_q  <= num_c;
			dsh_q  <= divisor_w << 8;
			flat_q <= job.flat;
		end else if (step_en) begin
			if (bit_ok) rem_q <= trial[mmn_pkg::NUM_W-1:0];
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[mmn_pkg::PIX_W-3:0], bit_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= direct || (step_en && last);
		end
	end

	always_ff @(posedge clk) begin
		if (direct) begin
			out_pix_q  <= (job.kind == mmn_pkg::KIND_FULL) ? mmn_pkg::PIX_MAX : '0;
			out_flat_q <= job.flat;
		end else if (step_en && last) begin
			out_pix_q  <= {quot_q, bit_ok};
			out_flat_q <= flat_q;
		end
	end

	assign pix_valid  = out_valid_q;
	assign pixel      = out_pix_q;
	assign flat_frame = out_flat_q;

endmodule

// ===== rtl/min_max_normalize_to_byte_unit.sv =====
// Min-max normaliser: clear and measure words update the frame minimum and maximum at
// once, so a normalise word that follows sees them. A normalise word is classified in
// the front end in the cycle after it is taken and waits in a four-entry job queue.
// Clamped results (sample at or below the minimum, or at or above minimum plus range)
// leave the back end in the cycle after leaving the queue; all others go through the
// restoring divider, one quotient bit per cycle unless the last bit waits on a stalled
// output; each such pixel takes a load and eight quotient bits, and the divider takes
// no new job until done. The front end keeps taking words while the queue has room.
`include "assert_macros.svh"

module min_max_normalize_to_byte_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [1:0]                opcode,
	input  logic signed [31:0]        sample,
	output logic                      pix_valid,
	input  logic                      pix_stall,
	output logic [mmn_pkg::PIX_W-1:0] pixel,
	output logic                      flat_frame
);

	mmn_pkg::mmn_job_t   push_job, pop_job;
	mmn_pkg::mmn_qstat_t qstat;
	logic                q_push, q_pop;

	mmn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.sample     (sample),
		.qstat      (qstat),
		.push       (q_push),
		.push_job   (push_job)
	);

	mmn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.qstat    (qstat)
	);

	mmn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (pop_job),
		.qstat      (qstat),
		.pop        (q_pop),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel      (pixel),
		.flat_frame (flat_frame)
	);

	`MMN_ASSERT(a_no_push_full, !(q_push && qstat.full), "job pushed into full queue")
	`MMN_ASSERT(a_no_pop_empty, !(q_pop && qstat.empty), "job popped from empty queue")
	`MMN_ASSERT_IMP(a_valid_hold, $past(pix_valid && pix_stall), pix_valid, "stalled word dropped")
	`MMN_ASSERT_IMP(a_pix_hold, $past(pix_valid && pix_stall), $stable(pixel), "stalled pixel changed")

endmodule

// ===== tb/tb_min_max_normalize_to_byte_unit.sv =====
// self-checking testbench for the min-max normaliser: directed corners, random frames, back-pressure
`timescale 1ns / 1ps

module tb_min_max_normalize_to_byte_unit;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RESET_CYCLES  = 8;
	localparam int RANDOM_WORDS  = 600;
	localparam int HOLD_CYCLES   = 300;
	localparam int PRESSURE_WORDS = 40;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [mmn_pkg::PIX_W-1:0] pixel;
		logic                      flat;
	} pix_word_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_stall;
	logic [1:0]                opcode = mmn_pkg::OP_CLEAR;
	logic signed [31:0]        sample = '0;
	logic                      pix_valid;
	logic                      pix_stall = 1'b0;
	logic [mmn_pkg::PIX_W-1:0] pixel;
	logic                      flat_frame;

	logic signed [mmn_pkg::SAMPLE_WIDTH-1:0] frame_min;
	logic signed [mmn_pkg::SAMPLE_WIDTH-1:0] frame_max;
	pix_word_t pending_pixels[$];

	int err_count = 0;
	int words_sent = 0;
	int pixels_checked = 0;
	int frames_sent = 0;
	int cycle_count = 0;
	int burst_left = 0;

	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int phase_cnt = 0;

	min_max_normalize_to_byte_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.opcode     (opcode),
		.sample     (sample),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel      (pixel),
		.flat_frame (flat_frame)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
				pending_pixels.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// expected pixel for a normalise word against the current frame statistics
	function automatic pix_word_t stretch_pixel(logic signed [mmn_pkg::SAMPLE_WIDTH-1:0] smp);
		longint span;
		longint diff;
		longint q;
		pix_word_t r;
		span = longint'(frame_max) - longint'(frame_min);
		diff = longint'(smp) - longint'(frame_min);
		r.flat = 1'b0;
		if (span <= 0) begin
			span = longint'(1) << mmn_pkg::FRACTION_BITS;
			r.flat = 1'b1;
		end
		if (diff <= 0) begin
			r.pixel = '0;
		end else if (diff >= span) begin
			r.pixel = mmn_pkg::PIX_MAX;
		end else begin
			q = (diff * 510 + span) / (2 * span);
			r.pixel = (q > 255) ? mmn_pkg::PIX_MAX : q[mmn_pkg::PIX_W-1:0];
		end
		return r;
	endfunction

	task automatic fold_word(logic [1:0] op, logic signed [31:0] smp);
		case (op)
			mmn_pkg::OP_CLEAR: begin
				frame_min = mmn_pkg::SAMPLE_MAX;
				frame_max = mmn_pkg::SAMPLE_MIN;
			end
			mmn_pkg::OP_MEASURE: begin
				if (smp < frame_min) frame_min = smp;
				if (smp > frame_max) frame_max = smp;
			end
			mmn_pkg::OP_NORMALIZE: begin
				pending_pixels.push_back(stretch_pixel(smp));
			end
			default: begin
			end
		endcase
	endtask

	// called at a rising edge; returns at the edge where the word was taken
	task automatic send_word(logic [1:0] op, logic signed [31:0] smp);
		item_valid <= 1'b1;
		opcode <= op;
		sample <= smp;
		do @(posedge clk); while (item_stall);
		fold_word(op, smp);
		if (op != OP_UNUSED) words_sent++;
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// bursts of random length with random gaps between them
	task automatic send_paced(logic [1:0] op, logic signed [31:0] smp);
		send_word(op, smp);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
		end
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		pix_word_t exp_w;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected word: pixel %0d flat_frame %0d", pixel, flat_frame);
				err_count++;
			end else begin
				exp_w = pending_pixels.pop_front();
				pixels_checked++;
				if (pixel !== exp_w.pixel) begin
					$error("pixel: expected %0d, actual %0d", exp_w.pixel, pixel);
					err_count++;
				end
				if (flat_frame !== exp_w.flat) begin
					$error("flat_frame: expected %0d, actual %0d", exp_w.flat, flat_frame);
					err_count++;
				end
			end
		end
	end

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pix_stall <= 1'b1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			pix_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			phase_cnt <= phase_cnt + 1;
			case (stall_mode)
				0: pix_stall <= 1'b0;
				1: pix_stall <= ($urandom_range(0, 99) < 30);
				2: pix_stall <= ((phase_cnt % 7) < 3);
				default: pix_stall <= ($urandom_range(0, 99) < 75);
			endcase
		end
	end

	task automatic test_before_measure();
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd0);
		send_word(mmn_pkg::OP_NORMALIZE, mmn_pkg::SAMPLE_MAX);
	endtask

	task automatic test_unused_opcode();
		send_word(OP_UNUSED, 32'hFFFF_FFFF);
		send_word(OP_UNUSED, 32'sd0);
	endtask

	task automatic test_extremes();
		send_word(mmn_pkg::OP_CLEAR, 32'h5A5A_A5A5);
		send_word(mmn_pkg::OP_MEASURE, mmn_pkg::SAMPLE_MIN);
		send_word(mmn_pkg::OP_MEASURE, mmn_pkg::SAMPLE_MAX);
		send_word(mmn_pkg::OP_NORMALIZE, mmn_pkg::SAMPLE_MIN);
		send_word(mmn_pkg::OP_NORMALIZE, mmn_pkg::SAMPLE_MAX);
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd0);
		send_word(mmn_pkg::OP_NORMALIZE, -32'sd1);
	endtask

	// range of 510 steps puts odd differences exactly on a half
	task automatic test_rounding_and_clamps();
		send_word(mmn_pkg::OP_CLEAR, 32'sd0);
		send_word(mmn_pkg::OP_MEASURE, 32'sd0);
		send_word(mmn_pkg::OP_MEASURE, 32'sd510);
		send_word(mmn_pkg::OP_NORMALIZE, -32'sd1);
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd1);
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd3);
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd509);
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd510);
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd511);
	endtask

	task automatic test_flat_frame();
		send_word(mmn_pkg::OP_CLEAR, 32'sd0);
		send_word(mmn_pkg::OP_MEASURE, 32'sd5 <<< mmn_pkg::FRACTION_BITS);
		send_word(mmn_pkg::OP_NORMALIZE, (32'sd5 <<< mmn_pkg::FRACTION_BITS) + 32'sh8000);
		send_word(mmn_pkg::OP_NORMALIZE, 32'sd4 <<< mmn_pkg::FRACTION_BITS);
	endtask

	function automatic logic signed [31:0] frame_sample(int shape, logic signed [31:0] base);
		case (shape)
			0: return $urandom;
			1: return base + $urandom_range(0, 1 << 20);
			2: return base;
			default: return base + $urandom_range(0, 1000);
		endcase
	endfunction

	// mostly inside the measured range, some outside it and some anywhere
	function automatic logic signed [31:0] pick_normal_sample();
		longint span;
		longint v;
		longint unsigned r64;
		span = longint'(frame_max) - longint'(frame_min);
		r64 = {$urandom, $urandom};
		if (span < 0 || $urandom_range(0, 9) == 0) return $urandom;
		case ($urandom_range(0, 9))
			0: v = longint'(frame_min) - $urandom_range(0, 3);
			1: v = longint'(frame_max) + $urandom_range(0, 3);
			default: v = longint'(frame_min) + longint'(r64 % longint'(span + 1));
		endcase
		if (v > longint'(mmn_pkg::SAMPLE_MAX)) v = longint'(mmn_pkg::SAMPLE_MAX);
		if (v < longint'(mmn_pkg::SAMPLE_MIN)) v = longint'(mmn_pkg::SAMPLE_MIN);
		return v[31:0];
	endfunction

	task automatic test_random_frames();
		int start;
		int shape;
		int n_meas;
		int n_norm;
		logic signed [31:0] base;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) != 0) send_paced(mmn_pkg::OP_CLEAR, $urandom);
			frames_sent++;
			shape = $urandom_range(0, 3);
			base = $urandom;
			n_meas = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 10);
			repeat (n_meas) begin
				send_paced(mmn_pkg::OP_MEASURE, frame_sample(shape, base));
				if ($urandom_range(0, 19) == 0) send_paced(OP_UNUSED, $urandom);
			end
			n_norm = $urandom_range(1, 14);
			repeat (n_norm) begin
				send_paced(mmn_pkg::OP_NORMALIZE, pick_normal_sample());
				if ($urandom_range(0, 24) == 0) send_paced(OP_UNUSED, $urandom);
			end
		end
		wait_drain();
	endtask

	// receiver holds off while the sender keeps offering, so the job queue fills
	task automatic test_backpressure();
		send_word(mmn_pkg::OP_CLEAR, 32'sd0);
		send_word(mmn_pkg::OP_MEASURE, -32'sd1000);
		send_word(mmn_pkg::OP_MEASURE, 32'sd77777);
		hold_req++;
		repeat (PRESSURE_WORDS) send_word(mmn_pkg::OP_NORMALIZE, pick_normal_sample());
		wait_drain();
	endtask

	initial begin
		frame_min = mmn_pkg::SAMPLE_MAX;
		frame_max = mmn_pkg::SAMPLE_MIN;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_measure();
		test_unused_opcode();
		test_extremes();
		test_rounding_and_clamps();
		test_flat_frame();
		wait_drain();
		test_backpressure();
		test_random_frames();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$error("%0d expected pixels never arrived", pending_pixels.size());
			err_count++;
		end
		$display("covered %0d words over %0d random frames, %0d pixels checked",
			words_sent, frames_sent, pixels_checked);
		$display("corners, flat frames, half-way rounding and a full-queue hold-off included");
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
